FILE: rtl/tlct_pkg.sv
// Shared types, constants and helpers of the cluster translator.
package tlct_pkg;

  localparam int L1_DEPTH         = 1024;
  localparam int MAX_CLUSTER_BITS = 16;
  localparam int MIN_CLUSTER_BITS = 12;

  localparam int L1_AW    = $clog2(L1_DEPTH);
  localparam int L2_AW    = MAX_CLUSTER_BITS - 3;
  localparam int L2_DEPTH = 1 << L2_AW;

  localparam int OFS_W  = 56;
  localparam int LEN_W  = 16;
  localparam int WORD_W = 64;
  localparam int IDX_W  = 13;
  localparam int CB_W   = 5;
  localparam int L1S_W  = 11;
  // widest first-level index: offset shifted by the smallest first-level shift
  localparam int L1I_W  = OFS_W - (2 * MIN_CLUSTER_BITS - 3);
  // cluster size including the bit for the size itself
  localparam int CS_W   = MAX_CLUSTER_BITS + 1;
  localparam int COMPRESSED_BIT = 62;

  localparam logic [WORD_W-1:0] OFS_MASK = 64'h00ff_ffff_ffff_fe00;

  typedef enum logic [1:0] {
    OP_LOAD_L1 = 2'd0,
    OP_LOAD_L2 = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_IMAGE_SIZE   = 2'd0,
    CFG_CLUSTER_LOG2 = 2'd1,
    CFG_L1_ENTRIES   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_ZERO       = 3'd0,
    KIND_MAPPED     = 3'd1,
    KIND_MISS       = 3'd2,
    KIND_COMPRESSED = 3'd3,
    KIND_RANGE      = 3'd4,
    KIND_DONE       = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_L1_RD,
    ST_L1_CHK,
    ST_L2_CHK,
    ST_SEG,
    ST_EMIT
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [OFS_W-1:0]  host;
    logic [LEN_W-1:0]  seg_len;
    logic              last;
  } res_t;

  // table words arrive big-endian
  function automatic logic [WORD_W-1:0] swap64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

FILE: rtl/tlct_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
module tlct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tlct_out_reg.sv
// Output register that holds one result until the downstream side takes it.
module tlct_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  tlct_pkg::res_t res,
  input  logic           res_load,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output tlct_pkg::res_t out_res
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid && out_res == $past(res))
    else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/tlct_walker.sv
// Request sequencer: table loads, read clipping and the per-cluster table walk.
module tlct_walker (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic [tlct_pkg::OFS_W-1:0]     image_size,
  input  logic [tlct_pkg::CB_W-1:0]      cluster_log2,
  input  logic [tlct_pkg::L1S_W-1:0]     l1_entries,
  // request side
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [tlct_pkg::IDX_W-1:0]     entry_index,
  input  logic [tlct_pkg::OFS_W-1:0]     table_offset,
  input  logic [tlct_pkg::OFS_W-1:0]     guest_offset,
  input  logic [tlct_pkg::LEN_W-1:0]     read_length,
  // first-level memory
  output logic                           l1_we,
  output logic [tlct_pkg::L1_AW-1:0]     l1_waddr,
  output logic                           l1_re,
  output logic [tlct_pkg::L1_AW-1:0]     l1_raddr,
  input  logic [tlct_pkg::WORD_W-1:0]    l1_rdata,
  // second-level memory
  output logic                           l2_we,
  output logic [tlct_pkg::L2_AW-1:0]     l2_waddr,
  output logic                           l2_re,
  output logic [tlct_pkg::L2_AW-1:0]     l2_raddr,
  input  logic [tlct_pkg::WORD_W-1:0]    l2_rdata,
  // result side
  output tlct_pkg::res_t                 res,
  output logic                           res_load,
  input  logic                           slot_free
);

  tlct_pkg::state_t state, state_next;

  logic [tlct_pkg::OFS_W-1:0] off, off_next;
  logic [tlct_pkg::LEN_W-1:0] len, len_next;
  logic [tlct_pkg::OFS_W-1:0] tag, tag_next;
  logic [tlct_pkg::OFS_W-1:0] data_ofs, data_ofs_next;
  tlct_pkg::res_t             res_next;

  logic [tlct_pkg::CB_W-1:0]  cb;
  logic [5:0]                 dir_shift;
  logic [tlct_pkg::OFS_W-1:0] off_l1, off_l2;
  logic [tlct_pkg::L1I_W-1:0] l1i;
  logic [tlct_pkg::L2_AW-1:0] l2_mask;
  logic [tlct_pkg::OFS_W:0]   room_img;
  logic [tlct_pkg::OFS_W-1:0] l2o;
  logic [tlct_pkg::CS_W-1:0]  csize, coff, room;
  logic [tlct_pkg::LEN_W-1:0] rlen;

  // clamp cluster size to the supported range
  always_comb begin
    priority if (cluster_log2 < tlct_pkg::CB_W'(tlct_pkg::MIN_CLUSTER_BITS)) begin
      cb = tlct_pkg::CB_W'(tlct_pkg::MIN_CLUSTER_BITS);
    end else if (cluster_log2 > tlct_pkg::CB_W'(tlct_pkg::MAX_CLUSTER_BITS)) begin
      cb = tlct_pkg::CB_W'(tlct_pkg::MAX_CLUSTER_BITS);
    end else begin
      cb = cluster_log2;
    end
  end

  assign dir_shift = 6'({cb, 1'b0}) - 6'd3;
  assign off_l1   = off >> dir_shift;
  assign off_l2   = off >> cb;
  assign l1i      = off_l1[tlct_pkg::L1I_W-1:0];
  assign l2_mask  = (tlct_pkg::L2_AW'(1) << (cb - tlct_pkg::CB_W'(3))) - tlct_pkg::L2_AW'(1);
  assign room_img = {1'b0, image_size} - {1'b0, off};
  assign l2o      = l1_rdata[tlct_pkg::OFS_W-1:0] & tlct_pkg::OFS_MASK[tlct_pkg::OFS_W-1:0];

  assign csize = tlct_pkg::CS_W'(1) << cb;
  assign coff  = off[tlct_pkg::CS_W-1:0] & (csize - tlct_pkg::CS_W'(1));
  assign room  = csize - coff;
  assign rlen  = (tlct_pkg::CS_W'(len) > room) ? tlct_pkg::LEN_W'(room) : len;

  assign in_ready = (state == tlct_pkg::ST_IDLE);
  assign l1_waddr = tlct_pkg::L1_AW'(entry_index);
  assign l2_waddr = tlct_pkg::L2_AW'(entry_index);
  assign l1_raddr = tlct_pkg::L1_AW'(l1i);
  assign l2_raddr = tlct_pkg::L2_AW'(off_l2) & l2_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlct_pkg::ST_IDLE;
      tag   <= '0;
    end else begin
      state <= state_next;
      tag   <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    off      <= off_next;
    len      <= len_next;
    data_ofs <= data_ofs_next;
    res      <= res_next;
  end

  always_comb begin
    state_next    = state;
    off_next      = off;
    len_next      = len;
    tag_next      = tag;
    data_ofs_next = data_ofs;
    res_next      = res;
    l1_we         = 1'b0;
    l2_we         = 1'b0;
    l1_re         = 1'b0;
    l2_re         = 1'b0;
    res_load      = 1'b0;

    unique case (state)
      tlct_pkg::ST_IDLE: begin
        res_next = '{kind: tlct_pkg::KIND_DONE, host: '0, seg_len: '0, last: 1'b1};
        if (in_valid) begin
          state_next = tlct_pkg::ST_EMIT;
          unique case (opcode)
            tlct_pkg::OP_LOAD_L1: begin
              l1_we = (32'(entry_index) < tlct_pkg::L1_DEPTH);
            end
            tlct_pkg::OP_LOAD_L2: begin
              l2_we    = 1'b1;
              tag_next = table_offset;
            end
            tlct_pkg::OP_READ: begin
              off_next   = guest_offset;
              len_next   = read_length;
              state_next = tlct_pkg::ST_CLIP;
            end
            default: begin
            end
          endcase
        end
      end

      tlct_pkg::ST_CLIP: begin
        // past the end or nothing to read: answer done
        if (room_img[tlct_pkg::OFS_W] || room_img == '0 || len == '0) begin
          state_next = tlct_pkg::ST_EMIT;
        end else begin
          if (room_img[tlct_pkg::OFS_W-1:0] < tlct_pkg::OFS_W'(len)) begin
            len_next = room_img[tlct_pkg::LEN_W-1:0];
          end
          state_next = tlct_pkg::ST_L1_RD;
        end
      end

      tlct_pkg::ST_L1_RD: begin
        if (l1i >= tlct_pkg::L1I_W'(l1_entries) || l1i >= tlct_pkg::L1I_W'(tlct_pkg::L1_DEPTH)) begin
          res_next   = '{kind: tlct_pkg::KIND_RANGE, host: '0, seg_len: '0, last: 1'b1};
          state_next = tlct_pkg::ST_EMIT;
        end else begin
          l1_re      = 1'b1;
          state_next = tlct_pkg::ST_L1_CHK;
        end
      end

      tlct_pkg::ST_L1_CHK: begin
        priority if (l2o == '0) begin
          // unallocated: zero fill without a second-level lookup
          data_ofs_next = '0;
          state_next    = tlct_pkg::ST_SEG;
        end else if (l2o != tag) begin
          res_next   = '{kind: tlct_pkg::KIND_MISS, host: l2o, seg_len: '0, last: 1'b1};
          state_next = tlct_pkg::ST_EMIT;
        end else begin
          l2_re      = 1'b1;
          state_next = tlct_pkg::ST_L2_CHK;
        end
      end

      tlct_pkg::ST_L2_CHK: begin
        if (l2_rdata[tlct_pkg::COMPRESSED_BIT]) begin
          res_next   = '{kind: tlct_pkg::KIND_COMPRESSED, host: '0, seg_len: '0, last: 1'b1};
          state_next = tlct_pkg::ST_EMIT;
        end else begin
          data_ofs_next = l2_rdata[0] ? '0 :
                          l2_rdata[tlct_pkg::OFS_W-1:0] & tlct_pkg::OFS_MASK[tlct_pkg::OFS_W-1:0];
          state_next    = tlct_pkg::ST_SEG;
        end
      end

      tlct_pkg::ST_SEG: begin
        if (data_ofs != '0) begin
          res_next.kind = tlct_pkg::KIND_MAPPED;
          res_next.host = data_ofs + tlct_pkg::OFS_W'(coff);
        end else begin
          res_next.kind = tlct_pkg::KIND_ZERO;
          res_next.host = '0;
        end
        res_next.seg_len = rlen;
        res_next.last    = (len == rlen);
        off_next         = off + tlct_pkg::OFS_W'(rlen);
        len_next         = len - rlen;
        state_next       = tlct_pkg::ST_EMIT;
      end

      tlct_pkg::ST_EMIT: begin
        // hold the result until the output register has room
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = res.last ? tlct_pkg::ST_IDLE : tlct_pkg::ST_L1_RD;
        end
      end

      default: begin
        state_next = tlct_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> slot_free)
    else $error("result pushed into a full output register");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    res_load && res.last |=> in_ready)
    else $error("walker busy after final result");
  a_l2_hit_only: assert property (@(posedge clk) disable iff (rst)
    l2_re |-> l2o == tag && l2o != '0)
    else $error("second-level read without a tag hit");
  a_seg_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_load && (res.kind == tlct_pkg::KIND_ZERO || res.kind == tlct_pkg::KIND_MAPPED)
      |-> res.seg_len != '0)
    else $error("empty segment emitted");
`endif

endmodule

FILE: rtl/two_level_cluster_translator.sv
// Top level of the two-level table cluster address translator.
// Each request is taken only while the translator is idle. A table load
// (or unknown opcode) returns one done result once the output register
// has room. A read is accepted and clipped to the image size, then handled
// in cluster pieces: the first-level memory read, the second-level memory
// read (skipped when the first-level entry is unallocated), the segment
// arithmetic and the result hand-off, each dependent on the one before. A
// result waits in the output register while the next work proceeds up to
// the next hand-off. Table memories have no reset and are defined only
// once written.
module two_level_cluster_translator (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index[12:0], entry_word[76:13], table_offset[132:77],
  // guest_offset[188:133], read_length[204:189], zero[207:205]
  input  logic [207:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // host_offset[55:0], segment_length[71:56]
  output logic [71:0]  m_tdata,
  // kind[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  // configuration writes
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [55:0]  cfg_data
);

  logic [tlct_pkg::OFS_W-1:0]  image_size;
  logic [tlct_pkg::CB_W-1:0]   cluster_log2;
  logic [tlct_pkg::L1S_W-1:0]  l1_entries;

  logic [tlct_pkg::WORD_W-1:0] word_swapped;
  logic                        l1_we, l1_re, l2_we, l2_re;
  logic [tlct_pkg::L1_AW-1:0]  l1_waddr, l1_raddr;
  logic [tlct_pkg::L2_AW-1:0]  l2_waddr, l2_raddr;
  logic [tlct_pkg::WORD_W-1:0] l1_rdata, l2_rdata;

  tlct_pkg::res_t              res, out_res;
  logic                        res_load, slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size   <= '0;
      cluster_log2 <= tlct_pkg::CB_W'(16);
      l1_entries   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlct_pkg::CFG_IMAGE_SIZE:   image_size   <= cfg_data;
        tlct_pkg::CFG_CLUSTER_LOG2: cluster_log2 <= cfg_data[tlct_pkg::CB_W-1:0];
        tlct_pkg::CFG_L1_ENTRIES:   l1_entries   <= cfg_data[tlct_pkg::L1S_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign word_swapped = tlct_pkg::swap64(s_tdata[76:13]);

  tlct_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .image_size   (image_size),
    .cluster_log2 (cluster_log2),
    .l1_entries   (l1_entries),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .opcode       (s_tuser),
    .entry_index  (s_tdata[12:0]),
    .table_offset (s_tdata[132:77]),
    .guest_offset (s_tdata[188:133]),
    .read_length  (s_tdata[204:189]),
    .l1_we        (l1_we),
    .l1_waddr     (l1_waddr),
    .l1_re        (l1_re),
    .l1_raddr     (l1_raddr),
    .l1_rdata     (l1_rdata),
    .l2_we        (l2_we),
    .l2_waddr     (l2_waddr),
    .l2_re        (l2_re),
    .l2_raddr     (l2_raddr),
    .l2_rdata     (l2_rdata),
    .res          (res),
    .res_load     (res_load),
    .slot_free    (slot_free)
  );

  tlct_ram #(
    .WIDTH (tlct_pkg::WORD_W),
    .DEPTH (tlct_pkg::L1_DEPTH)
  ) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (word_swapped),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  tlct_ram #(
    .WIDTH (tlct_pkg::WORD_W),
    .DEPTH (tlct_pkg::L2_DEPTH)
  ) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (l2_waddr),
    .wdata (word_swapped),
    .re    (l2_re),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  tlct_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_load  (res_load),
    .slot_free (slot_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.seg_len, out_res.host};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule
